@@ hw/rtl/dtsw_pkg.sv @@
package dtsw_pkg;

    localparam int unsigned CfgW    = 21;
    localparam int unsigned OffsetW = 20;
    localparam int unsigned DepthW  = 7;
    localparam int unsigned WordsW  = 19;

    localparam logic [31:0] TagBegin   = 32'd1;
    localparam logic [31:0] TagEndNode = 32'd2;
    localparam logic [31:0] TagProp    = 32'd3;
    localparam logic [31:0] TagNop     = 32'd4;
    localparam logic [31:0] TagEnd     = 32'd9;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_NODE = 3'd1,
        EV_END  = 3'd2,
        EV_BAD  = 3'd3,
        EV_PAST = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_NAME    = 2'd1,
        PH_PHDR    = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef struct packed {
        event_t              ev;
        logic [OffsetW-1:0]  offset;
        logic [DepthW-1:0]   depth;
    } result_t;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

@@ hw/rtl/dtsw_parse.sv @@
module dtsw_parse #(
    parameter int unsigned MAX_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [31:0]                struct_word,
    input  logic                       first_word,
    input  logic [dtsw_pkg::CfgW-1:0]  limit,
    output dtsw_pkg::result_t          result
);

    localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int unsigned PosW    = dtsw_pkg::CfgW;

    dtsw_pkg::phase_t               phase_reg, phase_next;
    logic [PosW-1:0]                pos_reg, pos_next;
    logic [DEPTH_W-1:0]             open_reg, open_next;
    logic [dtsw_pkg::WordsW-1:0]    left_reg, left_next;
    logic [1:0]                     hdr_reg, hdr_next;
    logic                           halted_reg, halted_next;

    dtsw_pkg::phase_t               phase_cur;
    logic [PosW-1:0]                pos_cur;
    logic [DEPTH_W-1:0]             open_cur;
    logic [dtsw_pkg::WordsW-1:0]    left_cur, left_dec;
    logic [1:0]                     hdr_cur;
    logic                           halted_cur;
    logic [31:0]                    w;
    logic [32:0]                    padded;
    logic [33:0]                    prop_end;
    logic                           past_word;
    logic                           name_done;

    always_comb
    begin
        phase_cur  = first_word ? dtsw_pkg::PH_TAG : phase_reg;
        pos_cur    = first_word ? '0 : pos_reg;
        open_cur   = first_word ? '0 : open_reg;
        left_cur   = first_word ? '0 : left_reg;
        hdr_cur    = first_word ? '0 : hdr_reg;
        halted_cur = first_word ? 1'b0 : halted_reg;

        w         = dtsw_pkg::swap32(struct_word);
        past_word = ({1'b0, pos_cur} + (PosW+1)'(4)) > {1'b0, limit};
        padded    = ({1'b0, w} + 33'd3) & ~33'd3;
        prop_end  = 34'(pos_cur) + 34'd8 + {1'b0, padded};
        name_done = (struct_word[31:24] == 8'd0) || (struct_word[23:16] == 8'd0) ||
                    (struct_word[15:8] == 8'd0) || (struct_word[7:0] == 8'd0);
        left_dec  = (left_cur != '0) ? left_cur - 1'b1 : left_cur;
    end

    always_comb
    begin
        phase_next  = phase_cur;
        pos_next    = pos_cur;
        open_next   = open_cur;
        left_next   = left_cur;
        hdr_next    = hdr_cur;
        halted_next = halted_cur;

        if (!halted_cur)
        begin
            if (past_word)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                pos_next = pos_cur + PosW'(4);
                unique case (phase_cur)
                    dtsw_pkg::PH_TAG:
                    begin
                        if (w == dtsw_pkg::TagBegin)
                        begin
                            if (open_cur == DEPTH_W'(MAX_DEPTH))
                            begin
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                open_next  = open_cur + 1'b1;
                                phase_next = dtsw_pkg::PH_NAME;
                            end
                        end
                        else if (w == dtsw_pkg::TagEndNode)
                        begin
                            if (open_cur == '0)
                            begin
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                open_next = open_cur - 1'b1;
                            end
                        end
                        else if (w == dtsw_pkg::TagProp)
                        begin
                            phase_next = dtsw_pkg::PH_PHDR;
                            hdr_next   = 2'd2;
                        end
                        else if (w == dtsw_pkg::TagNop)
                        begin
                            phase_next = phase_cur;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                        end
                    end
                    dtsw_pkg::PH_NAME:
                    begin
                        if (name_done)
                        begin
                            phase_next = dtsw_pkg::PH_TAG;
                        end
                    end
                    dtsw_pkg::PH_PHDR:
                    begin
                        if (hdr_cur == 2'd2)
                        begin
                            if (prop_end > 34'(limit))
                            begin
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                left_next = padded[dtsw_pkg::WordsW+1:2];
                                hdr_next  = 2'd1;
                            end
                        end
                        else
                        begin
                            hdr_next   = 2'd0;
                            phase_next = (left_cur == '0) ? dtsw_pkg::PH_TAG
                                                          : dtsw_pkg::PH_PAYLOAD;
                        end
                    end
                    dtsw_pkg::PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            phase_next = dtsw_pkg::PH_TAG;
                        end
                    end
                    default:
                    begin
                        phase_next = dtsw_pkg::PH_TAG;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result = '{ev: dtsw_pkg::EV_NONE, offset: '0, depth: '0};

        if (!halted_cur)
        begin
            if (past_word)
            begin
                result.ev = dtsw_pkg::EV_PAST;
            end
            else
            begin
                unique case (phase_cur)
                    dtsw_pkg::PH_TAG:
                    begin
                        if (w == dtsw_pkg::TagBegin)
                        begin
                            if (open_cur == DEPTH_W'(MAX_DEPTH))
                            begin
                                result.ev = dtsw_pkg::EV_BAD;
                            end
                            else
                            begin
                                result.ev     = dtsw_pkg::EV_NODE;
                                result.offset = dtsw_pkg::OffsetW'(pos_cur);
                                result.depth  = dtsw_pkg::DepthW'(open_cur);
                            end
                        end
                        else if (w == dtsw_pkg::TagEndNode)
                        begin
                            if (open_cur == '0)
                            begin
                                result.ev = dtsw_pkg::EV_BAD;
                            end
                        end
                        else if (w == dtsw_pkg::TagEnd)
                        begin
                            result.ev = dtsw_pkg::EV_END;
                        end
                        else if ((w != dtsw_pkg::TagProp) && (w != dtsw_pkg::TagNop))
                        begin
                            result.ev = dtsw_pkg::EV_BAD;
                        end
                    end
                    dtsw_pkg::PH_PHDR:
                    begin
                        if ((hdr_cur == 2'd2) && (prop_end > 34'(limit)))
                        begin
                            result.ev = dtsw_pkg::EV_PAST;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dtsw_pkg::PH_TAG;
            pos_reg    <= '0;
            open_reg   <= '0;
            left_reg   <= '0;
            hdr_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            open_reg   <= open_next;
            left_reg   <= left_next;
            hdr_reg    <= hdr_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ hw/rtl/dtsw_out_stage.sv @@
module dtsw_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dtsw_pkg::result_t result,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output dtsw_pkg::result_t held
);

    logic              valid_reg, valid_next;
    dtsw_pkg::result_t data_reg;

    // take a new beat whenever the held one is empty or leaving this cycle
    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

@@ hw/rtl/device_tree_struct_walker_unit.sv @@
// Device tree structure block walker.
// Input channel (in_valid/in_ready): one beat per big-endian structure word;
// first_word marks the first word of a block and clears the parse state.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// carrying event_res, and tag_offset/node_depth for begin-node events.
// cfg_wr_en/cfg_wr_data set the structure block size in bytes; write it
// only while no beats are in flight.
// Each accepted word is parsed combinationally into one result register;
// out_valid rises in the cycle after accept. Throughput: one word per cycle
// while out_ready is high. in_ready is high while that register is empty
// or being drained; a stalled receiver holds the result and drops in_ready.
// Reset clears the parse state, the halt flag, the size register and the
// output valid. After an end tag, a bad structure or an overrun the walker
// reports event 0 for every word until first_word starts a new block.
module device_tree_struct_walker_unit #(
    parameter int unsigned MAX_BLOCK_BYTES = 1048576,
    parameter int unsigned MAX_DEPTH       = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dtsw_pkg::CfgW-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   struct_word,
    input  logic                          first_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    event_res,
    output logic [dtsw_pkg::OffsetW-1:0]  tag_offset,
    output logic [dtsw_pkg::DepthW-1:0]   node_depth
);

    localparam longint unsigned CfgMax   = (64'd1 << dtsw_pkg::CfgW) - 64'd1;
    localparam longint unsigned LimitCap = (64'(MAX_BLOCK_BYTES) > CfgMax) ? CfgMax
                                                                  : 64'(MAX_BLOCK_BYTES);

    logic [dtsw_pkg::CfgW-1:0] size_reg;
    logic [dtsw_pkg::CfgW-1:0] limit;
    logic                      accept;
    logic                      space;
    dtsw_pkg::result_t         result;
    dtsw_pkg::result_t         held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    assign limit    = (64'(size_reg) > LimitCap) ? dtsw_pkg::CfgW'(LimitCap) : size_reg;
    assign in_ready = space;
    assign accept   = in_valid && space;

    dtsw_parse #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .struct_word (struct_word),
        .first_word  (first_word),
        .limit       (limit),
        .result      (result)
    );

    dtsw_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign event_res  = held.ev;
    assign tag_offset = held.offset;
    assign node_depth = held.depth;

endmodule
